// File: sv/i2cmb_pkg.sv
package i2cmb_pkg;

    // Command codes of an input beat; the same codes name the operation in progress.
    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_RACK  = 3'd5,
        CMD_ACK   = 3'd6,
        CMD_NACK  = 3'd7
    } cmd_t;

    // With no operation in progress the operation register holds the tick code.
    localparam cmd_t OP_IDLE = CMD_TICK;

    // Register map: one 32-bit register, selected by paddr[2].
    localparam int  PADDR_W         = 3;
    localparam logic REG_HALF_PERIOD = 1'b0;
    localparam logic [15:0] HALF_PERIOD_RESET = 16'd5;

    localparam int BYTE_W = 8;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // One input beat.
    typedef struct packed {
        cmd_t              cmd;
        logic [BYTE_W-1:0] write_data;
        logic              sda_in;
    } item_t;

    // One result beat.
    typedef struct packed {
        logic              scl_out;
        logic              sda_out;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] read_data;
        logic              ack_bit;
        logic              rejected;
    } res_t;

endpackage

// File: sv/i2cmb_apb_regs.sv
module i2cmb_apb_regs
    import i2cmb_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [15:0]        half_period
);

    logic [15:0] half_period_reg;
    logic        wr_en;

    // The register is written in the access cycle of a write.
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_HALF_PERIOD);
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= HALF_PERIOD_RESET;
        end else if (wr_en) begin
            half_period_reg <= pwdata[15:0];
        end
    end

    // Read back; addresses beyond the register read as zero.
    always_comb begin
        if (paddr[2] == REG_HALF_PERIOD) begin
            prdata = {16'd0, half_period_reg};
        end else begin
            prdata = 32'd0;
        end
    end

    assign half_period = half_period_reg;

endmodule

// File: sv/i2cmb_seq.sv
module i2cmb_seq
    import i2cmb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  item_t       item,
    input  logic [15:0] half_period,
    output res_t        res
);

    cmd_t              op_reg, op_next;
    logic              phase_reg, phase_next;
    logic [15:0]       wait_reg, wait_next;
    logic [3:0]        bit_reg, bit_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic              ack_reg, ack_next;
    logic [BYTE_W-1:0] last_read_reg, last_read_next;

    logic [15:0]       hp_eff;
    logic [15:0]       wait_sum;
    logic [3:0]        bit_inc;
    logic [BYTE_W-1:0] shifted;
    logic [2:0]        drive_idx;
    logic              done;
    logic              rej;

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg        <= OP_IDLE;
            phase_reg     <= 1'b0;
            wait_reg      <= 16'd0;
            bit_reg       <= 4'd0;
            shift_reg     <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            ack_reg       <= 1'b1;
            last_read_reg <= '0;
        end else if (step) begin
            op_reg        <= op_next;
            phase_reg     <= phase_next;
            wait_reg      <= wait_next;
            bit_reg       <= bit_next;
            shift_reg     <= shift_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            ack_reg       <= ack_next;
            last_read_reg <= last_read_next;
        end
    end

    // A zero half period counts as one tick.
    assign hp_eff    = (half_period == 16'd0) ? 16'd1 : half_period;
    assign wait_sum  = wait_reg + 16'd1;
    assign bit_inc   = bit_reg + 4'd1;
    assign shifted   = {shift_reg[BYTE_W-2:0], item.sda_in};
    assign drive_idx = 3'd7 - bit_inc[2:0];

    // Next state per beat: start or reject a command, or advance the timer on a tick.
    always_comb begin
        op_next        = op_reg;
        phase_next     = phase_reg;
        wait_next      = wait_reg;
        bit_next       = bit_reg;
        shift_next     = shift_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        ack_next       = ack_reg;
        last_read_next = last_read_reg;
        done           = 1'b0;
        rej            = 1'b0;

        if (item.cmd != CMD_TICK) begin
            if (op_reg != OP_IDLE) begin
                rej = 1'b1;
            end else begin
                op_next    = item.cmd;
                phase_next = 1'b0;
                wait_next  = 16'd0;
                bit_next   = 4'd0;
                if (item.cmd == CMD_START) begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                end else if (item.cmd == CMD_STOP) begin
                    scl_next = 1'b0;
                    sda_next = 1'b0;
                end else begin
                    // Bit commands keep SCL where it is and set up the first SDA level.
                    shift_next = (item.cmd == CMD_WRITE) ? item.write_data : '0;
                    if (item.cmd == CMD_WRITE) begin
                        sda_next = item.write_data[BYTE_W-1];
                    end else if (item.cmd == CMD_ACK) begin
                        sda_next = 1'b0;
                    end else begin
                        sda_next = 1'b1;
                    end
                end
            end
        end else if (op_reg != OP_IDLE) begin
            if (wait_sum >= hp_eff) begin
                wait_next = 16'd0;
                if (op_reg == CMD_START) begin
                    if (!phase_reg) begin
                        sda_next   = 1'b0;
                        phase_next = 1'b1;
                    end else begin
                        scl_next = 1'b0;
                        done     = 1'b1;
                    end
                end else if (op_reg == CMD_STOP) begin
                    if (!phase_reg) begin
                        scl_next   = 1'b1;
                        phase_next = 1'b1;
                    end else begin
                        sda_next = 1'b1;
                        done     = 1'b1;
                    end
                end else if (!phase_reg) begin
                    scl_next   = 1'b1;
                    phase_next = 1'b1;
                end else begin
                    // End of the SCL-high phase: sample SDA and drop SCL.
                    scl_next = 1'b0;
                    bit_next = bit_inc;
                    if (op_reg == CMD_READ) begin
                        shift_next = shifted;
                    end
                    if (op_reg == CMD_RACK) begin
                        ack_next = item.sda_in;
                    end
                    if ((op_reg == CMD_WRITE || op_reg == CMD_READ)
                        && bit_inc < BITS_PER_BYTE) begin
                        phase_next = 1'b0;
                        sda_next   = (op_reg == CMD_WRITE) ? shift_reg[drive_idx] : 1'b1;
                    end else begin
                        if (op_reg == CMD_READ) begin
                            last_read_next = shifted;
                        end
                        done = 1'b1;
                    end
                end
                if (done) begin
                    op_next    = OP_IDLE;
                    phase_next = 1'b0;
                end
            end else begin
                wait_next = wait_sum;
            end
        end
    end

    // Result of this beat, taken from the updated state.
    always_comb begin
        res.scl_out   = scl_next;
        res.sda_out   = sda_next;
        res.busy_res  = (op_next != OP_IDLE);
        res.done_res  = done;
        res.read_data = last_read_next;
        res.ack_bit   = ack_next;
        res.rejected  = rej;
    end

endmodule

// File: sv/i2c_master_bit_engine.sv
// Channel   Dir  Handshake            Payload
// s_        in   s_valid / s_ready    s_cmd, s_write_data, s_sda_in
// m_        out  m_valid / m_ready    m_scl_out, m_sda_out, m_busy_res, m_done_res,
//                                     m_read_data, m_ack_bit, m_rejected
// apb       in   psel / penable       paddr, pwdata, pwrite; prdata, pready
//
// Each beat is held in the input register; when it moves on, the sequencer state
// and the result register are written together.
// One beat per cycle is sustained while the output is not stalled.
// A stalled result holds the output register; the input register still takes one more beat.
// Reset (aresetn low, synchronous) empties both registers, releases SCL and SDA and
// loads half_period with 5.
module i2c_master_bit_engine
    import i2cmb_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_cmd,
    input  logic [7:0]         s_write_data,
    input  logic               s_sda_in,

    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_scl_out,
    output logic               m_sda_out,
    output logic               m_busy_res,
    output logic               m_done_res,
    output logic [7:0]         m_read_data,
    output logic               m_ack_bit,
    output logic               m_rejected,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic        in_valid_reg;
    item_t       item_reg;
    logic        out_valid_reg;
    res_t        res_reg;
    res_t        res;
    logic        advance;
    logic [15:0] half_period;

    i2cmb_apb_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .half_period (half_period)
    );

    // The held beat moves on whenever the output register is free or being emptied.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= '{cmd: cmd_t'(s_cmd), write_data: s_write_data, sda_in: s_sda_in};
        end
    end

    i2cmb_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .item        (item_reg),
        .half_period (half_period),
        .res         (res)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_scl_out   = res_reg.scl_out;
    assign m_sda_out   = res_reg.sda_out;
    assign m_busy_res  = res_reg.busy_res;
    assign m_done_res  = res_reg.done_res;
    assign m_read_data = res_reg.read_data;
    assign m_ack_bit   = res_reg.ack_bit;
    assign m_rejected  = res_reg.rejected;

    // A rejected command leaves the running operation in place.
    a_rej_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rejected) |-> m_busy_res)
        else $error("rejected result without a busy sequencer");

    // A finished operation leaves the sequencer idle.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_done_res) |-> !m_busy_res)
        else $error("done result while still busy");

    // A beat that moves on shows up in the result register on the next cycle.
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("advanced beat lost before the result register");

    // Input is refused only when both registers are full and the output is stalled.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input refused without back-pressure");

endmodule

// File: test/i2c_line_checker.sv
`timescale 1ns / 1ps

module i2c_line_checker
    import i2cmb_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [2:0]         s_cmd,
    input  logic [7:0]         s_write_data,
    input  logic               s_sda_in,

    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_scl_out,
    input  logic               m_sda_out,
    input  logic               m_busy_res,
    input  logic               m_done_res,
    input  logic [7:0]         m_read_data,
    input  logic               m_ack_bit,
    input  logic               m_rejected,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    input  logic [31:0]        prdata,
    input  logic               pready,

    output int                 fail_count,
    output int                 lines_pending
);

    // Mirror of the sequencer: configuration, operation in progress and line levels.
    logic [15:0] hp_reg;
    cmd_t        op_now;
    logic [1:0]  phase_now;
    logic [15:0] tick_count;
    logic [3:0]  bit_count;
    logic [7:0]  shifter;
    logic        scl_drv;
    logic        sda_drv;
    logic        ack_seen;
    logic [7:0]  byte_read;

    // Line states predicted for accepted input beats, oldest first.
    res_t pending_lines[$];

    // SDA level that the current bit of the operation drives.
    function automatic logic drive_level();
        case (op_now)
            CMD_WRITE: return shifter[3'd7 - bit_count[2:0]];
            CMD_ACK:   return 1'b0;
            default:   return 1'b1;
        endcase
    endfunction

    // Advances the mirror by one input beat and returns the line state it leaves.
    function automatic res_t line_after_beat(cmd_t cmd, logic [7:0] data, logic sda);
        res_t        beat_out;
        logic [15:0] span;
        logic        finished;
        beat_out = '0;
        finished = 1'b0;
        span = (hp_reg == 16'd0) ? 16'd1 : hp_reg;

        if (cmd != CMD_TICK) begin
            // A command only starts when the line is idle.
            if (op_now != OP_IDLE) begin
                beat_out.rejected = 1'b1;
            end else begin
                op_now = cmd;
                phase_now = 2'd0;
                tick_count = 16'd0;
                bit_count = 4'd0;
                if (cmd == CMD_START) begin
                    scl_drv = 1'b1;
                    sda_drv = 1'b1;
                end else if (cmd == CMD_STOP) begin
                    scl_drv = 1'b0;
                    sda_drv = 1'b0;
                end else begin
                    shifter = (cmd == CMD_WRITE) ? data : 8'd0;
                    sda_drv = drive_level();
                end
            end
        end else if (op_now != OP_IDLE) begin
            tick_count = tick_count + 16'd1;
            if (tick_count >= span) begin
                tick_count = 16'd0;
                case (op_now)
                    CMD_START: begin
                        if (phase_now == 2'd0) begin
                            sda_drv = 1'b0;
                            phase_now = 2'd1;
                        end else begin
                            scl_drv = 1'b0;
                            finished = 1'b1;
                        end
                    end
                    CMD_STOP: begin
                        if (phase_now == 2'd0) begin
                            scl_drv = 1'b1;
                            phase_now = 2'd1;
                        end else begin
                            sda_drv = 1'b1;
                            finished = 1'b1;
                        end
                    end
                    default: begin
                        if (phase_now == 2'd0) begin
                            scl_drv = 1'b1;
                            phase_now = 2'd1;
                        end else begin
                            // SCL falls; read operations sample SDA on this tick.
                            scl_drv = 1'b0;
                            if (op_now == CMD_READ)
                                shifter = {shifter[6:0], sda};
                            else if (op_now == CMD_RACK)
                                ack_seen = sda;
                            bit_count = bit_count + 4'd1;
                            if ((op_now == CMD_WRITE || op_now == CMD_READ) &&
                                bit_count < BITS_PER_BYTE) begin
                                phase_now = 2'd0;
                                sda_drv = drive_level();
                            end else begin
                                if (op_now == CMD_READ)
                                    byte_read = shifter;
                                finished = 1'b1;
                            end
                        end
                    end
                endcase
                if (finished) begin
                    beat_out.done_res = 1'b1;
                    op_now = OP_IDLE;
                    phase_now = 2'd0;
                end
            end
        end

        beat_out.scl_out = scl_drv;
        beat_out.sda_out = sda_drv;
        beat_out.busy_res = (op_now != OP_IDLE);
        beat_out.read_data = byte_read;
        beat_out.ack_bit = ack_seen;
        return beat_out;
    endfunction

    task automatic check_field(input string what, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, what, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin : monitor
        res_t want;
        res_t got;
        if (!aresetn) begin
            hp_reg = HALF_PERIOD_RESET;
            op_now = OP_IDLE;
            phase_now = 2'd0;
            tick_count = 16'd0;
            bit_count = 4'd0;
            shifter = 8'd0;
            scl_drv = 1'b1;
            sda_drv = 1'b1;
            ack_seen = 1'b1;
            byte_read = 8'd0;
            fail_count = 0;
            pending_lines.delete();
        end else begin
            // Register access: track writes, check read-back data.
            if (psel && penable && pready && paddr[2] == REG_HALF_PERIOD) begin
                if (pwrite)
                    hp_reg = pwdata[15:0];
                else
                    check_field("prdata half_period", hp_reg, prdata[15:0]);
            end

            // Result beats are matched against the oldest prediction.
            if (m_valid && m_ready) begin
                got.scl_out = m_scl_out;
                got.sda_out = m_sda_out;
                got.busy_res = m_busy_res;
                got.done_res = m_done_res;
                got.read_data = m_read_data;
                got.ack_bit = m_ack_bit;
                got.rejected = m_rejected;
                if (pending_lines.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result beat, expected none, actual %0h",
                             $time, got);
                end else begin
                    want = pending_lines.pop_front();
                    check_field("scl_out", want.scl_out, got.scl_out);
                    check_field("sda_out", want.sda_out, got.sda_out);
                    check_field("busy_res", want.busy_res, got.busy_res);
                    check_field("done_res", want.done_res, got.done_res);
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("ack_bit", want.ack_bit, got.ack_bit);
                    check_field("rejected", want.rejected, got.rejected);
                end
            end

            // Input beats update the mirror in acceptance order.
            if (s_valid && s_ready)
                pending_lines.push_back(line_after_beat(cmd_t'(s_cmd), s_write_data, s_sda_in));
        end
        lines_pending <= pending_lines.size();
    end

endmodule

// File: test/i2c_master_bit_engine_tb.sv
`timescale 1ns / 1ps

module i2c_master_bit_engine_tb;
    import i2cmb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_BEATS    = 110;
    localparam int LONG_TICKS     = 40;
    localparam logic [PADDR_W-1:0] HALF_PERIOD_ADDR = {REG_HALF_PERIOD, 2'b00};

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [2:0]         s_cmd;
    logic [7:0]         s_write_data;
    logic               s_sda_in;
    logic               m_valid;
    logic               m_ready;
    logic               m_scl_out;
    logic               m_sda_out;
    logic               m_busy_res;
    logic               m_done_res;
    logic [7:0]         m_read_data;
    logic               m_ack_bit;
    logic               m_rejected;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int fail_count;
    int lines_pending;
    int beats_sent;
    int cur_half;
    int idle_cycles;
    bit steady;
    bit hold_request;

    always #4 aclk = ~aclk;

    i2c_master_bit_engine dut (.*);

    i2c_line_checker line_chk (.*);

    // Gap length for either side: mostly none, sometimes short, rarely long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offers one input beat and returns at the edge where it is accepted.
    task automatic send_beat(input cmd_t c, input logic [7:0] data, input logic sda);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= c;
        s_write_data <= data;
        s_sda_in <= sda;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
    endtask

    // One line operation followed by exactly the ticks it needs. SDA follows the
    // pattern MSB first, one bit per bit period; a busy command can be slipped in.
    task automatic run_op(input cmd_t op, input logic [7:0] data, input logic [7:0] pattern,
                          input int reject_at, input bit noisy);
        int span;
        int ticks;
        int t;
        int bit_pos;
        logic sda;
        span = (cur_half == 0) ? 1 : cur_half;
        ticks = (op == CMD_WRITE || op == CMD_READ) ? 16 * span : 2 * span;
        send_beat(op, data, 1'($urandom_range(0, 1)));
        for (t = 0; t < ticks; t++) begin
            if (t == reject_at)
                send_beat(cmd_t'($urandom_range(1, 7)), 8'($urandom), 1'($urandom_range(0, 1)));
            bit_pos = 7 - t / (2 * span);
            sda = pattern[bit_pos];
            if (noisy && $urandom_range(0, 7) == 0)
                sda = ~sda;
            send_beat(CMD_TICK, 8'($urandom), sda);
        end
    endtask

    // Enough ticks to finish any operation, then the sender goes quiet.
    task automatic drain_line();
        int span;
        span = (cur_half == 0) ? 1 : cur_half;
        repeat (16 * span + 1) send_beat(CMD_TICK, 8'($urandom), 1'($urandom_range(0, 1)));
        s_valid <= 1'b0;
    endtask

    // Writes half_period once every result is back, then reads it.
    task automatic set_half_period(input logic [15:0] value);
        @(posedge aclk);
        while (lines_pending != 0) @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= HALF_PERIOD_ADDR;
        pwdata <= {16'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        cur_half = value;
    endtask

    // Mostly well-formed operations with random content, some idle ticks and noise.
    task automatic random_phase(input int n_beats);
        int stop_at;
        int r;
        int reject_at;
        stop_at = beats_sent + n_beats;
        while (beats_sent < stop_at) begin
            r = $urandom_range(0, 99);
            steady = ($urandom_range(0, 5) == 0);
            if (r < 82) begin
                reject_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : -1;
                run_op(cmd_t'($urandom_range(1, 7)), 8'($urandom), 8'($urandom),
                       reject_at, 1'b1);
            end else if (r < 92) begin
                repeat ($urandom_range(1, 4))
                    send_beat(CMD_TICK, 8'($urandom), 1'($urandom_range(0, 1)));
            end else begin
                send_beat(cmd_t'($urandom_range(0, 7)), 8'($urandom),
                          1'($urandom_range(0, 1)));
            end
        end
        steady = 1'b0;
        drain_line();
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin : result_sink
        int stall;
        bit hold_taken;
        hold_taken = 1'b0;
        m_ready = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            stall = pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Watchdog: too long without any beat moving on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[i2c_master_bit_engine] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_cmd = CMD_TICK;
        s_write_data = 8'd0;
        s_sda_in = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = 32'd0;
        beats_sent = 0;
        steady = 1'b0;
        hold_request = 1'b0;
        cur_half = HALF_PERIOD_RESET;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset half period: idle ticks, start, write, read ack and stop; start and stop each get a busy command.
        send_beat(CMD_TICK, 8'h00, 1'b0);
        send_beat(CMD_TICK, 8'hFF, 1'b1);
        run_op(CMD_START, 8'h00, 8'h00, 3, 1'b0);
        run_op(CMD_WRITE, 8'hA5, 8'hFF, -1, 1'b0);
        run_op(CMD_RACK, 8'h00, 8'h00, -1, 1'b0);
        run_op(CMD_STOP, 8'h00, 8'hFF, 0, 1'b0);
        s_valid <= 1'b0;

        // Zero half period behaves as one tick per phase.
        set_half_period(16'd0);
        run_op(CMD_START, 8'h00, 8'h00, -1, 1'b0);
        run_op(CMD_WRITE, 8'hFF, 8'h00, -1, 1'b0);
        run_op(CMD_WRITE, 8'h00, 8'hFF, 5, 1'b0);
        run_op(CMD_RACK, 8'h00, 8'h80, -1, 1'b0);
        run_op(CMD_READ, 8'h00, 8'h5A, -1, 1'b0);
        run_op(CMD_ACK, 8'h00, 8'hFF, -1, 1'b0);
        run_op(CMD_READ, 8'h00, 8'hFF, -1, 1'b0);
        run_op(CMD_NACK, 8'h00, 8'h00, -1, 1'b0);
        run_op(CMD_READ, 8'h00, 8'h00, 1, 1'b0);
        run_op(CMD_STOP, 8'h00, 8'h00, -1, 1'b0);
        send_beat(CMD_TICK, 8'h3C, 1'b0);
        s_valid <= 1'b0;

        // Shortest phase, with the result side held off to back up the input.
        set_half_period(16'd1);
        hold_request = 1'b1;
        random_phase(PHASE_BEATS);

        set_half_period(16'd2);
        random_phase(PHASE_BEATS);

        // Longest phase: a start condition, ticks and a busy write offered back to back, then
        // the half period is lowered mid phase so the phase ends on the next tick.
        set_half_period(16'hFFFF);
        steady = 1'b1;
        send_beat(CMD_START, 8'h00, 1'b1);
        repeat (LONG_TICKS) send_beat(CMD_TICK, 8'($urandom), 1'($urandom_range(0, 1)));
        send_beat(CMD_WRITE, 8'($urandom), 1'b0);
        steady = 1'b0;
        s_valid <= 1'b0;

        set_half_period(16'd3);
        drain_line();
        random_phase(PHASE_BEATS);

        set_half_period(16'd1);
        random_phase(PHASE_BEATS);

        set_half_period(16'd7);
        random_phase(PHASE_BEATS);

        // Let the last results come back before the verdict.
        @(posedge aclk);
        while (lines_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("[i2c_master_bit_engine] OK");
        else
            $display("[i2c_master_bit_engine] ERROR");
        $finish;
    end

endmodule

// File: i2c_master_bit_engine.f
sv/i2cmb_pkg.sv
sv/i2cmb_apb_regs.sv
sv/i2cmb_seq.sv
sv/i2c_master_bit_engine.sv
test/i2c_line_checker.sv
test/i2c_master_bit_engine_tb.sv
